FILE: hdl/ilr_pkg.sv
// Shared types, constants and helpers for the incremental linear regression block.
`timescale 1ns / 1ps

package ilr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int Q_BITS      = 48;
  localparam int SMALL_BITS  = 17;
  localparam int ACC_BITS    = 128;
  localparam int DVD_BITS    = 160;
  localparam int DSR_BITS    = 128;
  localparam int ROOT_BITS   = DVD_BITS / 2;
  localparam int ITER_BITS   = 8;

  localparam logic [SMALL_BITS-1:0] MAX_POINTS = 17'd65536;

  // request: one sample
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x_value;
    logic signed [SAMPLE_BITS-1:0] y_value;
    logic                          restart;
  } ilr_req_t;

  // result of one fit
  typedef struct packed {
    logic signed [Q_BITS-1:0] intercept;
    logic signed [Q_BITS-1:0] slope;
    logic [SMALL_BITS-1:0]    determination;
    logic [SMALL_BITS-1:0]    correlation;
    logic [Q_BITS-1:0]        std_error;
    logic [SMALL_BITS-1:0]    point_count;
    logic                     fit_valid;
  } ilr_rsp_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  // command to the shared arithmetic unit
  typedef struct packed {
    logic                 start;
    alu_op_e              op;
    logic                 clear;
    logic                 sub;
    logic [63:0]          a;
    logic [63:0]          b;
    logic [DVD_BITS-1:0]  dvd;
    logic [DSR_BITS-1:0]  dsr;
    logic [ITER_BITS-1:0] iters;
  } alu_cmd_t;

  // saturate a rounded magnitude with sign into Q32.16
  function automatic logic [Q_BITS-1:0] sat_q(input logic [95:0] mag, input logic neg);
    logic [95:0] lim;
    lim = 96'd1 << (Q_BITS - 1);
    if (!neg) begin
      return (mag >= lim) ? {1'b0, {(Q_BITS-1){1'b1}}} : mag[Q_BITS-1:0];
    end
    return (mag > lim) ? {1'b1, {(Q_BITS-1){1'b0}}} : (~mag[Q_BITS-1:0] + 48'd1);
  endfunction

endpackage

FILE: hdl/ilr_alu.sv
// Shared multi-cycle unit: digit-serial multiply-accumulate, restoring divide, square root.
`timescale 1ns / 1ps

module ilr_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ilr_pkg::alu_cmd_t           cmd_i,
  output logic                        done_o,
  output logic [ilr_pkg::ACC_BITS-1:0] acc_o,
  output logic [ilr_pkg::DVD_BITS-1:0] quot_o,
  output logic [ilr_pkg::ROOT_BITS-1:0] root_o
);
  import ilr_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } alu_state_e;

  alu_state_e           state_q;
  logic                 done_q;
  logic [1:0]           dig_q;
  logic [ITER_BITS-1:0] iter_q;

  logic [ACC_BITS-1:0]  acc_q;
  logic [63:0]          mca_q;
  logic [63:0]          mcb_q;
  logic                 neg_q;
  logic [DVD_BITS-1:0]  dvd_q;
  logic [DSR_BITS-1:0]  dsr_q;
  logic [DSR_BITS:0]    rem_q;
  logic [ROOT_BITS-1:0] root_q;

  logic [79:0]          prod;
  logic [ACC_BITS-1:0]  prod_sh;
  logic [DSR_BITS:0]    sub_a;
  logic [DSR_BITS:0]    sub_b;
  logic [DSR_BITS+1:0]  diff;
  logic                 ge;

  // 64x16 partial product, placed by digit position
  assign prod = mca_q * mcb_q[15:0];

  always_comb begin
    unique case (dig_q)
      2'd0: prod_sh = {48'b0, prod};
      2'd1: prod_sh = {32'b0, prod, 16'b0};
      2'd2: prod_sh = {16'b0, prod, 32'b0};
      2'd3: prod_sh = {prod, 48'b0};
      default: prod_sh = '0;
    endcase
  end

  // one subtractor shared by divide and root steps
  always_comb begin
    if (state_q == A_SQRT) begin
      sub_a = {45'b0, rem_q[81:0], dvd_q[DVD_BITS-1 -: 2]};
      sub_b = {45'b0, 2'b00, root_q, 2'b01};
    end else begin
      sub_a = {rem_q[DSR_BITS-1:0], dvd_q[DVD_BITS-1]};
      sub_b = {1'b0, dsr_q};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[DSR_BITS+1];
  end

  // sequencing of the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      dig_q   <= '0;
      iter_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (cmd_i.start) begin
            dig_q  <= '0;
            iter_q <= cmd_i.iters;
            unique case (cmd_i.op)
              OP_MUL:  state_q <= A_MUL;
              OP_DIV:  state_q <= A_DIV;
              OP_SQRT: state_q <= A_SQRT;
              default: state_q <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          dig_q <= dig_q + 2'd1;
          if (dig_q == 2'd3) begin
            state_q <= A_IDLE;
            done_q  <= 1'b1;
          end
        end
        A_DIV, A_SQRT: begin
          iter_q <= iter_q - 1'b1;
          if (iter_q == 8'd1) begin
            state_q <= A_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (cmd_i.start) begin
          mca_q  <= cmd_i.a[63] ? (~cmd_i.a + 64'd1) : cmd_i.a;
          mcb_q  <= cmd_i.b[63] ? (~cmd_i.b + 64'd1) : cmd_i.b;
          neg_q  <= cmd_i.a[63] ^ cmd_i.b[63] ^ cmd_i.sub;
          dvd_q  <= cmd_i.dvd;
          dsr_q  <= cmd_i.dsr;
          rem_q  <= '0;
          root_q <= '0;
          if (cmd_i.clear && cmd_i.op == OP_MUL) begin
            acc_q <= '0;
          end
        end
      end
      A_MUL: begin
        acc_q <= neg_q ? (acc_q - prod_sh) : (acc_q + prod_sh);
        mcb_q <= mcb_q >> 16;
      end
      A_DIV: begin
        rem_q <= ge ? diff[DSR_BITS:0] : sub_a;
        dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
      end
      A_SQRT: begin
        rem_q  <= ge ? diff[DSR_BITS:0] : sub_a;
        root_q <= {root_q[ROOT_BITS-2:0], ge};
        dvd_q  <= {dvd_q[DVD_BITS-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;
  assign quot_o = dvd_q;
  assign root_o = root_q;

endmodule

FILE: hdl/incremental_linear_regression.sv
// Incremental least-squares line fit: running sums and a sequenced fit per sample.
//
// Input channel: in_valid_i / in_stall_o carry one (x, y, restart) request. A request
// is taken when valid is high and stall is low; restart clears the set first. When
// the set already holds the maximum point count, the sample is dropped and the fit
// of the existing set is reported.
// Output channel: out_valid_o / out_stall_i carry one result per request: intercept,
// slope, R^2, correlation, standard error, point count and a fit valid flag.
// The sums update at acceptance, then one shared unit computes the fit.
// It runs 13 wide products (4 digit passes of a 64x16 multiplier each), five
// restoring divides (one quotient bit per cycle) and two square roots (one root
// bit per cycle). With zero y spread the R^2 and correlation steps are skipped;
// with zero x spread the fit stops after that spread; with fewer than three
// points no step runs. One request is in work at a time, so the block takes no
// new request until the result of the last one is in the output register.
// A finished result sits in an output register; the block takes the next request
// while it waits, and only holds its own result write until that register drains.
// Reset clears the point count and all sums and empties the output register.
`timescale 1ns / 1ps

module incremental_linear_regression (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ilr_pkg::ilr_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ilr_pkg::ilr_rsp_t out_rsp_o
);
  import ilr_pkg::*;

  localparam int RND_BITS    = FRAC_BITS + 1;
  localparam int SLOPE_ITERS = 80;
  localparam int ICPT_ITERS  = 96;
  localparam int DET_ITERS   = 144;
  localparam int FULL_ITERS  = DVD_BITS;
  localparam int SH_SLOPE    = RND_BITS + DVD_BITS - SLOPE_ITERS;
  localparam int SH_ICPT     = RND_BITS + DVD_BITS - ICPT_ITERS;
  localparam int SH_DET      = RND_BITS + DVD_BITS - DET_ITERS;
  localparam int SH_WIDE     = 2 * FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  typedef enum logic [19:0] {
    S_DX0   = 20'h00001,
    S_DX1   = 20'h00002,
    S_DY0   = 20'h00004,
    S_DY1   = 20'h00008,
    S_NXY0  = 20'h00010,
    S_NXY1  = 20'h00020,
    S_INUM0 = 20'h00040,
    S_INUM1 = 20'h00080,
    S_NSQ   = 20'h00100,
    S_P0    = 20'h00200,
    S_P1    = 20'h00400,
    S_NN    = 20'h00800,
    S_DEN   = 20'h01000,
    S_SLOPE = 20'h02000,
    S_ICPT  = 20'h04000,
    S_DET   = 20'h08000,
    S_CQ    = 20'h10000,
    S_CORR  = 20'h20000,
    S_SQ    = 20'h40000,
    S_SE    = 20'h80000
  } step_e;

  state_e state_q;
  step_e  step_q;
  logic   wait_q;
  logic   out_valid_q;

  // running sums
  logic [SMALL_BITS-1:0] cnt_q;
  logic signed [32:0]    sx_q, sy_q;
  logic [46:0]           sxx_q, syy_q;
  logic signed [47:0]    sxy_q;

  // fit temporaries
  logic [63:0]         dx_q, dy_q, nxy_q;
  logic [79:0]         inum_q;
  logic [ACC_BITS-1:0] nsq_q, p_q, resid_q, den_q;
  logic [33:0]         nn_q;
  ilr_rsp_t            res_q, out_q;

  // sample update
  logic signed [31:0]    pxx, pyy, pxy;
  logic [SMALL_BITS-1:0] cnt_base, cnt_d;
  logic signed [32:0]    sx_base, sy_base;
  logic [46:0]           sxx_base, syy_base;
  logic signed [47:0]    sxy_base;
  logic                  add_en;
  logic                  accept;

  alu_cmd_t            cmd;
  logic                alu_done;
  logic [ACC_BITS-1:0] alu_acc;
  logic [DVD_BITS-1:0] alu_quot;
  logic [ROOT_BITS-1:0] alu_root;
  logic                step_done;
  logic [63:0]         n64;
  logic [63:0]         mag_nxy;
  logic [79:0]         mag_inum;
  logic [96:0]         q_inc;
  logic [95:0]         q_round;
  step_e               step_next;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign step_done  = (state_q == ST_CALC) && wait_q && alu_done;
  assign step_next  = step_e'({step_q[18:0], 1'b0});

  // new sums for an accepted sample
  always_comb begin
    pxx      = in_req_i.x_value * in_req_i.x_value;
    pyy      = in_req_i.y_value * in_req_i.y_value;
    pxy      = in_req_i.x_value * in_req_i.y_value;
    cnt_base = in_req_i.restart ? '0 : cnt_q;
    sx_base  = in_req_i.restart ? '0 : sx_q;
    sy_base  = in_req_i.restart ? '0 : sy_q;
    sxx_base = in_req_i.restart ? '0 : sxx_q;
    syy_base = in_req_i.restart ? '0 : syy_q;
    sxy_base = in_req_i.restart ? '0 : sxy_q;
    add_en   = (cnt_base != MAX_POINTS);
    cnt_d    = cnt_base + {16'b0, add_en};
  end

  // operand magnitudes and quotient rounding
  always_comb begin
    n64      = {47'b0, cnt_q};
    mag_nxy  = nxy_q[63] ? (~nxy_q + 64'd1) : nxy_q;
    mag_inum = inum_q[79] ? (~inum_q + 80'd1) : inum_q;
    q_inc    = {1'b0, alu_quot[95:0]} + 97'd1;
    q_round  = q_inc[96:1];
  end

  // command for the current step
  always_comb begin
    cmd       = '0;
    cmd.start = (state_q == ST_CALC) && !wait_q;
    cmd.op    = OP_MUL;
    cmd.iters = 8'(FULL_ITERS);
    unique case (step_q)
      S_DX0:   begin cmd.clear = 1'b1; cmd.a = n64; cmd.b = 64'(sxx_q); end
      S_DX1:   begin cmd.sub = 1'b1; cmd.a = 64'(sx_q); cmd.b = 64'(sx_q); end
      S_DY0:   begin cmd.clear = 1'b1; cmd.a = n64; cmd.b = 64'(syy_q); end
      S_DY1:   begin cmd.sub = 1'b1; cmd.a = 64'(sy_q); cmd.b = 64'(sy_q); end
      S_NXY0:  begin cmd.clear = 1'b1; cmd.a = n64; cmd.b = 64'(sxy_q); end
      S_NXY1:  begin cmd.sub = 1'b1; cmd.a = 64'(sx_q); cmd.b = 64'(sy_q); end
      S_INUM0: begin cmd.clear = 1'b1; cmd.a = 64'(sy_q); cmd.b = 64'(sxx_q); end
      S_INUM1: begin cmd.sub = 1'b1; cmd.a = 64'(sx_q); cmd.b = 64'(sxy_q); end
      S_NSQ:   begin cmd.clear = 1'b1; cmd.a = nxy_q; cmd.b = nxy_q; end
      S_P0:    begin cmd.clear = 1'b1; cmd.a = dx_q; cmd.b = dy_q; end
      S_P1:    begin cmd.sub = 1'b1; cmd.a = nxy_q; cmd.b = nxy_q; end
      S_NN:    begin cmd.clear = 1'b1; cmd.a = n64; cmd.b = n64 - 64'd2; end
      S_DEN:   begin cmd.clear = 1'b1; cmd.a = 64'(nn_q); cmd.b = dx_q; end
      S_SLOPE: begin
        cmd.op    = OP_DIV;
        cmd.dvd   = DVD_BITS'(mag_nxy) << SH_SLOPE;
        cmd.dsr   = DSR_BITS'(dx_q);
        cmd.iters = 8'(SLOPE_ITERS);
      end
      S_ICPT:  begin
        cmd.op    = OP_DIV;
        cmd.dvd   = DVD_BITS'(mag_inum) << SH_ICPT;
        cmd.dsr   = DSR_BITS'(dx_q);
        cmd.iters = 8'(ICPT_ITERS);
      end
      S_DET:   begin
        cmd.op    = OP_DIV;
        cmd.dvd   = DVD_BITS'(nsq_q) << SH_DET;
        cmd.dsr   = p_q;
        cmd.iters = 8'(DET_ITERS);
      end
      S_CQ:    begin
        cmd.op  = OP_DIV;
        cmd.dvd = DVD_BITS'(nsq_q) << SH_WIDE;
        cmd.dsr = p_q;
      end
      S_CORR:  begin
        cmd.op    = OP_SQRT;
        cmd.dvd   = alu_quot;
        cmd.iters = 8'(ROOT_BITS);
      end
      S_SQ:    begin
        cmd.op  = OP_DIV;
        cmd.dvd = DVD_BITS'(resid_q) << SH_WIDE;
        cmd.dsr = den_q;
      end
      S_SE:    begin
        cmd.op    = OP_SQRT;
        cmd.dvd   = alu_quot;
        cmd.iters = 8'(ROOT_BITS);
      end
      default: cmd.start = 1'b0;
    endcase
  end

  ilr_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .done_o (alu_done),
    .acc_o  (alu_acc),
    .quot_o (alu_quot),
    .root_o (alu_root)
  );

  // control: sums, sequencer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_DX0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      sxy_q       <= '0;
    end else begin
      // drained result; a finishing request refills the register below
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q   <= cnt_d;
            sx_q    <= add_en ? (sx_base + 33'(in_req_i.x_value)) : sx_base;
            sy_q    <= add_en ? (sy_base + 33'(in_req_i.y_value)) : sy_base;
            sxx_q   <= add_en ? (sxx_base + 47'(pxx)) : sxx_base;
            syy_q   <= add_en ? (syy_base + 47'(pyy)) : syy_base;
            sxy_q   <= add_en ? (sxy_base + 48'(pxy)) : sxy_base;
            step_q  <= S_DX0;
            wait_q  <= 1'b0;
            state_q <= (cnt_d < 17'd3) ? ST_FINISH : ST_CALC;
          end
        end
        ST_CALC: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (alu_done) begin
            wait_q <= 1'b0;
            unique case (step_q)
              S_DX1: begin
                if (alu_acc[63:0] == 64'd0) state_q <= ST_FINISH;
                else step_q <= step_next;
              end
              S_ICPT:  step_q <= (dy_q == 64'd0) ? S_SQ : S_DET;
              S_SE:    state_q <= ST_FINISH;
              default: step_q <= step_next;
            endcase
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath: step results and output register
  always_ff @(posedge clk_i) begin
    // fresh result: only the point count is known yet
    if (accept) begin
      res_q <= {{(3 * Q_BITS + 2 * SMALL_BITS){1'b0}}, cnt_d, 1'b0};
    end
    if (step_done) begin
      unique case (step_q)
        S_DX1:   dx_q    <= alu_acc[63:0];
        S_DY1:   dy_q    <= alu_acc[63:0];
        S_NXY1:  nxy_q   <= alu_acc[63:0];
        S_INUM1: inum_q  <= alu_acc[79:0];
        S_NSQ:   nsq_q   <= alu_acc;
        S_P0:    p_q     <= alu_acc;
        S_P1:    resid_q <= alu_acc[ACC_BITS-1] ? '0 : alu_acc;
        S_NN:    nn_q    <= alu_acc[33:0];
        S_DEN:   den_q   <= alu_acc;
        S_SLOPE: res_q.slope     <= sat_q(q_round, nxy_q[63]);
        S_ICPT:  res_q.intercept <= sat_q(q_round, inum_q[79]);
        S_DET:   begin
          res_q.determination <= q_round[SMALL_BITS-1:0];
          res_q.fit_valid     <= 1'b1;
        end
        S_CORR:  res_q.correlation <= alu_root[SMALL_BITS-1:0];
        S_SE:    res_q.std_error <= (alu_root[ROOT_BITS-1:Q_BITS] != '0) ? '1
                                                                     : alu_root[Q_BITS-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_FINISH && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: hdl/ilr_checker.sv
// Port-level checks for the incremental linear regression block, bound to its top level.
`timescale 1ns / 1ps

module ilr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ilr_pkg::ilr_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ilr_pkg::ilr_rsp_t out_rsp_o
);
  import ilr_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // a valid fit needs three points and has a bounded R^2
  a_fit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.fit_valid |-> out_rsp_o.point_count >= 17'd3 &&
      out_rsp_o.determination <= 17'd65536 && out_rsp_o.correlation <= 17'd65536)
    else $error("fit valid with bad count or R^2");

  // too few points gives an empty fit
  a_few_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.point_count < 17'd3 |-> out_rsp_o.slope == '0 &&
      out_rsp_o.intercept == '0 && out_rsp_o.std_error == '0 && !out_rsp_o.fit_valid)
    else $error("fit reported for fewer than three points");

  // no R^2 without a valid fit
  a_no_r2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.fit_valid |->
      out_rsp_o.determination == '0 && out_rsp_o.correlation == '0)
    else $error("R^2 reported without valid fit");

endmodule

bind incremental_linear_regression ilr_checker u_ilr_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the incremental linear regression block.
`timescale 1ns / 1ps

module tb;
  import ilr_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 1200;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  ilr_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  ilr_rsp_t out_rsp;

  incremental_linear_regression DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  ilr_req_t sample_q[$];
  ilr_rsp_t fit_q[$];
  int       mismatches = 0;
  int       fits_seen = 0;

  // predictor state: running sums of the sample set
  int    pt_count = 0;
  wide_t acc_x = '0, acc_y = '0, acc_xx = '0, acc_yy = '0, acc_xy = '0;

  function automatic logic [255:0] isqrt(input logic [255:0] v);
    logic [255:0] root, trial;
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      trial = root | (256'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // round(mag * 2^16 / den), halves rounded up
  function automatic wide_t round_div(input wide_t mag, input wide_t den);
    wide_t q, r;
    q = (mag <<< FRAC_BITS) / den;
    r = (mag <<< FRAC_BITS) % den;
    if ((r <<< 1) >= den) q = q + 1;
    return q;
  endfunction

  function automatic logic [Q_BITS-1:0] signed_quot(input wide_t num, input wide_t den);
    wide_t q, lim;
    logic  neg;
    neg = num < 0;
    q = round_div(neg ? -num : num, den);
    lim = wide_t'(1) <<< (Q_BITS - 1);
    if (!neg) return (q >= lim) ? Q_BITS'(lim - 1) : q[Q_BITS-1:0];
    if (q > lim) q = lim;
    return Q_BITS'(-q);
  endfunction

  // update the sums with one sample and compute the expected fit
  function automatic ilr_rsp_t fit_sample(input ilr_req_t req);
    ilr_rsp_t res;
    wide_t xs, ys, n, dx, dy, nxy, nsq, prod, resid, den, root;
    if (req.restart) begin
      pt_count = 0;
      acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;
    end
    if (pt_count < int'(MAX_POINTS)) begin
      xs = req.x_value;
      ys = req.y_value;
      pt_count++;
      acc_x += xs;
      acc_y += ys;
      acc_xx += xs * xs;
      acc_yy += ys * ys;
      acc_xy += xs * ys;
    end
    res = '0;
    res.point_count = SMALL_BITS'(pt_count);
    if (pt_count < 3) return res;
    n = pt_count;
    dx = n * acc_xx - acc_x * acc_x;
    if (dx == 0) return res;
    dy = n * acc_yy - acc_y * acc_y;
    nxy = n * acc_xy - acc_x * acc_y;
    res.slope = signed_quot(nxy, dx);
    res.intercept = signed_quot(acc_y * acc_xx - acc_x * acc_xy, dx);
    nsq = nxy * nxy;
    prod = dx * dy;
    if (dy != 0) begin
      res.determination = SMALL_BITS'(round_div(nsq, prod));
      res.correlation = SMALL_BITS'(isqrt((nsq <<< 32) / prod));
      res.fit_valid = 1'b1;
    end
    resid = prod - nsq;
    if (resid < 0) resid = '0;
    den = n * (n - 2) * dx;
    root = isqrt((resid <<< 32) / den);
    res.std_error = ((root >>> Q_BITS) == 0) ? root[Q_BITS-1:0] : {Q_BITS{1'b1}};
    return res;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH fit %0d %s: got %h expected %h", fits_seen, field, got, want);
  endtask

  // driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      if (in_valid && !in_stall) fit_q.push_back(fit_sample(in_req));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_req <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off partway through
  int hold_left = 0;
  bit hold_done = 0;
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase++;
      if (!hold_done && fits_seen == 400) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((stall_phase / 500) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // monitor: compare each result with the oldest expected fit
  ilr_rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (fit_q.size() == 0) begin
        report("unexpected result", 64'(out_rsp.point_count), 64'd0);
      end else begin
        want = fit_q.pop_front();
        if (out_rsp.intercept !== want.intercept)
          report("intercept", 64'(out_rsp.intercept), 64'(want.intercept));
        if (out_rsp.slope !== want.slope)
          report("slope", 64'(out_rsp.slope), 64'(want.slope));
        if (out_rsp.determination !== want.determination)
          report("determination", 64'(out_rsp.determination), 64'(want.determination));
        if (out_rsp.correlation !== want.correlation)
          report("correlation", 64'(out_rsp.correlation), 64'(want.correlation));
        if (out_rsp.std_error !== want.std_error)
          report("std_error", 64'(out_rsp.std_error), 64'(want.std_error));
        if (out_rsp.point_count !== want.point_count)
          report("point_count", 64'(out_rsp.point_count), 64'(want.point_count));
        if (out_rsp.fit_valid !== want.fit_valid)
          report("fit_valid", 64'(out_rsp.fit_valid), 64'(want.fit_valid));
      end
      fits_seen++;
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic ilr_req_t mk(input int x, input int y, input bit rs);
    ilr_req_t r;
    r.x_value = 16'(x);
    r.y_value = 16'(y);
    r.restart = rs;
    return r;
  endfunction

  // stimulus
  initial begin
    int span;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // few points, then extremes on a perfect line, then one point off it
    sample_q.push_back(mk(-32768, -32768, 0));
    sample_q.push_back(mk(32767, 32767, 0));
    sample_q.push_back(mk(0, 0, 0));
    sample_q.push_back(mk(1, -1, 0));
    // zero x spread
    sample_q.push_back(mk(5, 7, 1));
    sample_q.push_back(mk(5, -9, 0));
    sample_q.push_back(mk(5, 100, 0));
    // zero y spread
    sample_q.push_back(mk(-32768, 32767, 1));
    sample_q.push_back(mk(32767, 32767, 0));
    sample_q.push_back(mk(0, 32767, 0));
    // steep slope and large intercept
    sample_q.push_back(mk(0, -32768, 1));
    sample_q.push_back(mk(1, 32767, 0));
    sample_q.push_back(mk(0, -32768, 0));
    sample_q.push_back(mk(1, 32767, 0));
    // scattered extremes
    sample_q.push_back(mk(-32768, 32767, 1));
    sample_q.push_back(mk(32767, -32768, 0));
    sample_q.push_back(mk(-1, -1, 0));
    sample_q.push_back(mk(32767, 32767, 0));
    sample_q.push_back(mk(-32768, -32768, 0));

    // random sequences, mostly restarted sets of varied size and spread
    sample_q.push_back(mk($urandom, $urandom, 1));
    span = 65535;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 65535;
        sample_q.push_back(mk($urandom, $urandom, 1));
      end else if (span < 65535) begin
        sample_q.push_back(mk($urandom_range(0, span) - 3, $urandom, 0));
      end else begin
        sample_q.push_back(mk($urandom, $urandom, 0));
      end
    end

    wait (sample_q.size() == 0 && !in_valid && fit_q.size() == 0);
    repeat (1000) @(posedge clk_i);
    if (mismatches == 0 && fit_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
